// ===== rtl/u8sw_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sw_pkg
// Types and constants shared by the bounded UTF-8 string writer modules.
// ----------------------------------------------------------------------------
package u8sw_pkg;

  localparam int CFG_W      = 17;
  localparam int VALUE_W    = 21;
  localparam int COUNT_W    = 16;
  localparam int OADDR_W    = 16;
  localparam int QDEPTH     = 2;

  localparam logic [CFG_W-1:0] BUF_SIZE_RESET = 17'd4096;

  localparam logic [VALUE_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [VALUE_W-1:0] CP_3BYTE_MAX = 21'h00FFFF;
  localparam logic [VALUE_W-1:0] CP_2BYTE_MAX = 21'h0007FF;
  localparam logic [VALUE_W-1:0] CP_1BYTE_MAX = 21'h00007F;

  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] CONT  = 8'h80;

  typedef enum logic [1:0] {
    FUNC_RAW   = 2'd0,
    FUNC_CP    = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_NO_ROOM = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic [OADDR_W-1:0] out_addr;
    logic [1:0]         status;
    logic               last;
    logic [COUNT_W-1:0] char_count;
  } out_item_t;

  // one queued write: up to four bytes, first byte in element 0
  typedef struct packed {
    logic [3:0][7:0]    bytes;
    logic [1:0]         last_idx;
    logic [OADDR_W-1:0] addr;
    status_t            status;
    logic [COUNT_W-1:0] char_count;
  } job_t;

endpackage

// ===== rtl/u8sw_front.sv =====
// ----------------------------------------------------------------------------
// u8sw_front
// Accepts items, encodes codepoints, checks room and keeps position and count.
// ----------------------------------------------------------------------------
module u8sw_front #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  u8sw_pkg::in_item_t         in_data,
  input  logic [u8sw_pkg::CFG_W-1:0] size_limit,
  output logic                       push_valid,
  input  logic                       push_ready,
  output u8sw_pkg::job_t             push_data
);
  import u8sw_pkg::*;

  localparam int CW = ((ADDR_WIDTH > CFG_W) ? ADDR_WIDTH : CFG_W) + 2;
  localparam logic [CW-1:0] CAP = CW'(1) << ADDR_WIDTH;

  logic [ADDR_WIDTH-1:0] pos_r, pos_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;

  logic                  fire;
  logic                  is_write;
  logic                  bad_cp;
  logic [1:0]            n_m1;
  logic [3:0][7:0]       bytes;
  logic [VALUE_W-1:0]    cp;
  logic [CW-1:0]         size_ext, eff_size, end_pos;
  logic                  no_room;

  assign cp       = in_data.value;
  assign in_ready = push_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    is_write = 1'b0;
    bad_cp   = 1'b0;
    n_m1     = 2'd0;
    bytes    = '0;
    unique case (func_t'(in_data.func))
      FUNC_RAW: begin
        is_write = 1'b1;
        bytes[0] = cp[7:0];
      end
      FUNC_CP: begin
        is_write = 1'b1;
        if (cp > CP_MAX) begin
          bad_cp = 1'b1;
        end else if (cp > CP_3BYTE_MAX) begin
          n_m1     = 2'd3;
          bytes[0] = LEAD4 | {5'd0, cp[20:18]};
          bytes[1] = CONT | {2'd0, cp[17:12]};
          bytes[2] = CONT | {2'd0, cp[11:6]};
          bytes[3] = CONT | {2'd0, cp[5:0]};
        end else if (cp > CP_2BYTE_MAX) begin
          n_m1     = 2'd2;
          bytes[0] = LEAD3 | {4'd0, cp[15:12]};
          bytes[1] = CONT | {2'd0, cp[11:6]};
          bytes[2] = CONT | {2'd0, cp[5:0]};
        end else if (cp > CP_1BYTE_MAX) begin
          n_m1     = 2'd1;
          bytes[0] = LEAD2 | {3'd0, cp[10:6]};
          bytes[1] = CONT | {2'd0, cp[5:0]};
        end else begin
          bytes[0] = {1'b0, cp[6:0]};
        end
      end
      default: begin
        is_write = 1'b0;
      end
    endcase
  end

  // room check keeps one byte for the terminator
  assign size_ext = CW'(size_limit);
  assign eff_size = (size_ext < CAP) ? size_ext : CAP;
  assign end_pos  = CW'(pos_r) + CW'(n_m1) + CW'(1);
  assign no_room  = end_pos >= eff_size;

  always_comb begin
    push_valid           = fire && is_write;
    push_data.bytes      = bytes;
    push_data.last_idx   = n_m1;
    push_data.addr       = OADDR_W'(pos_r);
    push_data.status     = ST_OK;
    push_data.char_count = count_r + COUNT_W'(1);
    pos_nxt              = pos_r;
    count_nxt            = count_r;
    if (bad_cp || no_room) begin
      push_data.bytes      = '0;
      push_data.last_idx   = 2'd0;
      push_data.status     = bad_cp ? ST_RANGE : ST_NO_ROOM;
      push_data.char_count = count_r;
    end
    if (fire) begin
      if (func_t'(in_data.func) == FUNC_CLEAR) begin
        pos_nxt   = '0;
        count_nxt = '0;
      end else if (is_write && !bad_cp && !no_room) begin
        pos_nxt   = pos_r + ADDR_WIDTH'(n_m1) + ADDR_WIDTH'(1);
        count_nxt = count_r + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/u8sw_queue.sv =====
// ----------------------------------------------------------------------------
// u8sw_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module u8sw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  u8sw_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output u8sw_pkg::job_t pop_data
);
  import u8sw_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  job_t          mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign push_ready = cnt_r != NW'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

endmodule

// ===== rtl/u8sw_back.sv =====
// ----------------------------------------------------------------------------
// u8sw_back
// Sends out the bytes of each queued job, one result transfer per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module u8sw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  u8sw_pkg::job_t      pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output u8sw_pkg::out_item_t out_data
);
  import u8sw_pkg::*;

  job_t       job_r;
  logic       job_valid_r;
  logic [1:0] idx_r;
  logic       is_last;

  assign is_last   = idx_r == job_r.last_idx;
  assign out_valid = job_valid_r;
  // take the next job as the final byte of the current one leaves
  assign pop_ready = !job_valid_r || (out_ready && is_last);

  always_comb begin
    out_data.out_byte   = job_r.bytes[idx_r];
    out_data.out_addr   = job_r.addr + OADDR_W'(idx_r);
    out_data.status     = job_r.status;
    out_data.last       = is_last;
    out_data.char_count = job_r.char_count;
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job_r <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (pop_valid && pop_ready) begin
      job_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (job_valid_r && out_ready) begin
      if (is_last) begin
        job_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/bounded_utf8_string_writer_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_utf8_string_writer_unit
// The first result byte passes through the job queue entry and the back job register.
// Throughput: one result byte per cycle while out_ready is high; an item producing
// n bytes (1 to 4) holds the output for all n of them.
// The byte output stage sets the rate; a two-entry job queue decouples input.
// Reset (synchronous, rst_n low): position and count zero, size register 4096.
// ----------------------------------------------------------------------------
module bounded_utf8_string_writer_unit #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  u8sw_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output u8sw_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [u8sw_pkg::CFG_W-1:0] cfg_data
);
  import u8sw_pkg::*;

  logic [CFG_W-1:0] buf_size_r;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  job_t             push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= BUF_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      buf_size_r <= cfg_data;
    end
  end

  u8sw_front #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .size_limit (buf_size_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  u8sw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  u8sw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/u8sw_writer_checker.sv =====
// ----------------------------------------------------------------------------
// u8sw_writer_checker
// Watches the input, result and size-register channels of the UTF-8 string
// writer, predicts every result byte from its own copy of write position,
// character count and buffer size, and compares each result transfer field by
// field with the oldest predicted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module u8sw_writer_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  u8sw_pkg::in_item_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  u8sw_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [u8sw_pkg::CFG_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);
  import u8sw_pkg::*;

  logic [CFG_W-1:0]   size_q;
  logic [OADDR_W-1:0] wr_pos;
  logic [COUNT_W-1:0] n_chars;
  out_item_t          byte_q[$];
  int                 errs = 0;
  int                 n_checked = 0;

  task automatic report(input string msg);
    errs++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic queue_byte(input logic [7:0] b, input status_t st, input logic lst);
    out_item_t r;
    r.out_byte   = b;
    r.out_addr   = wr_pos;
    r.status     = st;
    r.last       = lst;
    r.char_count = n_chars;
    byte_q.push_back(r);
  endtask

  // model of one accepted item: clear, or encode, check room and queue the bytes or a status byte
  task automatic predict_write(input in_item_t it);
    logic [7:0]         enc [4];
    logic [VALUE_W-1:0] cp;
    status_t            st;
    int                 n;
    int                 lim;
    cp  = it.value;
    st  = ST_OK;
    n   = 0;
    lim = (int'(size_q) > (1 << OADDR_W)) ? (1 << OADDR_W) : int'(size_q);
    for (int k = 0; k < 4; k++) enc[k] = 8'h00;
    case (func_t'(it.func))
      FUNC_CLEAR: begin
        wr_pos  = '0;
        n_chars = '0;
      end
      FUNC_RAW: begin
        enc[0] = cp[7:0];
        n = 1;
      end
      FUNC_CP: begin
        if (cp > CP_MAX) begin
          st = ST_RANGE;
        end else if (cp > CP_3BYTE_MAX) begin
          enc[0] = LEAD4 | {5'd0, cp[20:18]};
          enc[1] = CONT | {2'd0, cp[17:12]};
          enc[2] = CONT | {2'd0, cp[11:6]};
          enc[3] = CONT | {2'd0, cp[5:0]};
          n = 4;
        end else if (cp > CP_2BYTE_MAX) begin
          enc[0] = LEAD3 | {4'd0, cp[15:12]};
          enc[1] = CONT | {2'd0, cp[11:6]};
          enc[2] = CONT | {2'd0, cp[5:0]};
          n = 3;
        end else if (cp > CP_1BYTE_MAX) begin
          enc[0] = LEAD2 | {3'd0, cp[10:6]};
          enc[1] = CONT | {2'd0, cp[5:0]};
          n = 2;
        end else begin
          enc[0] = {1'b0, cp[6:0]};
          n = 1;
        end
      end
      default: ;
    endcase
    // one byte always stays free for the terminator
    if (st == ST_OK && n > 0 && int'(wr_pos) + n >= lim)
      st = ST_NO_ROOM;
    if (st != ST_OK) begin
      queue_byte(8'h00, st, 1'b1);
    end else if (n > 0) begin
      n_chars = n_chars + COUNT_W'(1);
      for (int k = 0; k < n; k++) begin
        queue_byte(enc[k], ST_OK, k == n - 1);
        wr_pos = wr_pos + OADDR_W'(1);
      end
    end
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (byte_q.size() == 0) begin
      report($sformatf("result transfer with nothing predicted (byte %0h addr %0h)",
                       got.out_byte, got.out_addr));
    end else begin
      want = byte_q.pop_front();
      n_checked++;
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte got %0h expected %0h at addr %0h",
                         got.out_byte, want.out_byte, want.out_addr));
      if (got.out_addr !== want.out_addr)
        report($sformatf("out_addr got %0h expected %0h", got.out_addr, want.out_addr));
      if (got.status !== want.status)
        report($sformatf("status got %0d expected %0d at addr %0h",
                         got.status, want.status, want.out_addr));
      if (got.last !== want.last)
        report($sformatf("last got %0b expected %0b at addr %0h",
                         got.last, want.last, want.out_addr));
      if (got.char_count !== want.char_count)
        report($sformatf("char_count got %0h expected %0h at addr %0h",
                         got.char_count, want.char_count, want.out_addr));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      size_q  = BUF_SIZE_RESET;
      wr_pos  = '0;
      n_chars = '0;
      byte_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) size_q = cfg_data;
      if (in_valid && in_ready) predict_write(in_data);
      if (out_valid && out_ready) check_byte(out_data);
    end
    fail_count <= errs;
    pending    <= byte_q.size();
    checked    <= n_checked;
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bounded UTF-8 string writer. Directed edge
// codepoints and buffer sizes first, then random mixes of raw bytes, codepoints,
// clears and unused items over small buffer sizes and one of 65536, then a short
// run with a size beyond the address space. Both sides idle at random in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import u8sw_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 100;
  localparam int SETTLE       = 8;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 42;
  localparam int FILL_4BYTE   = 16;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int  fail_count;
  int  pending;
  int  checked;
  int  n_sent = 0;
  int  n_sizes = 0;
  int  idle_cycles = 0;
  bit  idle_on = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bounded_utf8_string_writer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  u8sw_writer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  function automatic in_item_t item(input func_t f, input logic [VALUE_W-1:0] v);
    in_item_t it;
    it.func  = f;
    it.value = v;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       sel;
    sel      = $urandom_range(0, 99);
    it.value = VALUE_W'($urandom_range(0, 21'h1FFFFF));
    if (sel < 30) begin
      it.func = FUNC_RAW;
    end else if (sel < 88) begin
      it.func = FUNC_CP;
      case ($urandom_range(0, 5))
        0: it.value = VALUE_W'($urandom_range(0, CP_1BYTE_MAX));
        1: it.value = VALUE_W'($urandom_range(CP_1BYTE_MAX + 1, CP_2BYTE_MAX));
        2: it.value = VALUE_W'($urandom_range(CP_2BYTE_MAX + 1, CP_3BYTE_MAX));
        3: it.value = VALUE_W'($urandom_range(21'h00D800, 21'h00DFFF));
        4: it.value = VALUE_W'($urandom_range(CP_3BYTE_MAX + 1, CP_MAX));
        default: it.value = VALUE_W'($urandom_range(CP_MAX + 1, 21'h1FFFFF));
      endcase
    end else if (sel < 95) begin
      it.func = FUNC_CLEAR;
    end else begin
      it.func = FUNC_NONE;
    end
    return it;
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // wait until every predicted byte has gone out, let clears settle, write size
  task automatic set_size(input logic [CFG_W-1:0] sz);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_sizes++;
  endtask

  // result side: random stalls, plus one long hold-off to back up the input
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (!held && checked >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d bytes still due",
               idle_cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] sz;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size, encoding boundaries, out of range, unused and clear
    send(item(FUNC_RAW, 21'h000000));
    send(item(FUNC_RAW, 21'h1FFFFF));
    send(item(FUNC_CP, 21'h000000));
    send(item(FUNC_CP, CP_1BYTE_MAX));
    send(item(FUNC_CP, CP_1BYTE_MAX + VALUE_W'(1)));
    send(item(FUNC_CP, CP_2BYTE_MAX));
    send(item(FUNC_CP, CP_2BYTE_MAX + VALUE_W'(1)));
    send(item(FUNC_CP, 21'h00D800));
    send(item(FUNC_CP, 21'h00DFFF));
    send(item(FUNC_CP, CP_3BYTE_MAX));
    send(item(FUNC_CP, CP_3BYTE_MAX + VALUE_W'(1)));
    send(item(FUNC_CP, CP_MAX));
    send(item(FUNC_CP, CP_MAX + VALUE_W'(1)));
    send(item(FUNC_CP, 21'h1FFFFF));
    send(item(FUNC_NONE, 21'h1FFFFF));
    send(item(FUNC_CLEAR, 21'h000000));
    send(item(FUNC_RAW, 21'h000041));

    // zero and one byte buffers reject everything
    set_size(17'd0);
    send(item(FUNC_RAW, 21'h000055));
    send(item(FUNC_CP, 21'h0020AC));
    set_size(17'd1);
    send(item(FUNC_RAW, 21'h000000));

    // four bytes fit in five, the next one does not
    set_size(17'd5);
    send(item(FUNC_CLEAR, 21'h000000));
    send(item(FUNC_CP, 21'h01F600));
    send(item(FUNC_RAW, 21'h00007A));
    send(item(FUNC_CLEAR, 21'h000000));
    send(item(FUNC_CP, 21'h0020AC));

    for (int p = 0; p < PHASES; p++) begin
      sz = (p == 3) ? 17'd65536 : 17'($urandom_range(2, 48));
      set_size(sz);
      idle_on = (p % 3 != 2);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send(rand_item());
    end

    // size beyond the address space acts as the full address space
    set_size(17'h1FFFF);
    idle_on = 1'b0;
    send(item(FUNC_CLEAR, 21'h000000));
    for (int i = 0; i < FILL_4BYTE; i++)
      send(item(FUNC_CP, VALUE_W'($urandom_range(CP_3BYTE_MAX + 1, CP_MAX))));
    send(item(FUNC_CP, VALUE_W'($urandom_range(CP_1BYTE_MAX + 1, CP_2BYTE_MAX))));
    send(item(FUNC_RAW, VALUE_W'($urandom_range(0, 21'h1FFFFF))));
    send(item(FUNC_RAW, VALUE_W'($urandom_range(0, 21'h1FFFFF))));
    send(item(FUNC_CP, VALUE_W'($urandom_range(0, CP_1BYTE_MAX))));
    send(item(FUNC_CLEAR, 21'h000000));

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d input transfers and %0d result bytes over %0d buffer sizes,",
             n_sent, checked, n_sizes);
    $display("including zero, one, 2^16 and above-address-space sizes and a long stall");
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
